[hdl/sms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shifter package
// Shared types and codes for the SPI master shifter: request actions, end
// policies, configuration register indexes, and the state and result records.
// ----------------------------------------------------------------------------
package sms_pkg;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_SELECT = 2'd2,
        ACT_END    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MID_NONE      = 2'd0,
        MID_STOP      = 2'd1,
        MID_CONTINUE  = 2'd2,
        MID_EXIT_CONT = 2'd3
    } t_mid_mode;

    typedef enum logic [1:0] {
        REG_CLOCK_IDLE_HIGH    = 2'd0,
        REG_SAMPLE_SECOND_EDGE = 2'd1,
        REG_LSB_FIRST          = 2'd2,
        REG_NINE_BIT_FRAME     = 2'd3
    } t_reg_idx;

    localparam logic [3:0] BITS_BYTE = 4'd8;
    localparam logic [3:0] BITS_NINE = 4'd9;

    typedef struct packed {
        logic clock_idle_high;
        logic sample_second_edge;
        logic lsb_first;
        logic nine_bit_frame;
    } t_cfg;

    typedef struct packed {
        logic [7:0] shift_reg;
        logic [3:0] bits_left;
        logic       half_phase;
        logic       dc_pending;
        logic       sck;
        logic       mosi;
        logic       cs;
        logic       tail_release;
    } t_state;

    typedef struct packed {
        t_action    action;
        logic [7:0] tx_byte;
        logic       dc_bit;
        logic       miso_level;
        t_mid_mode  mid_mode;
        logic       last_message;
    } t_item;

    typedef struct packed {
        logic       sck_level;
        logic       mosi_level;
        logic       cs_n;
        logic       busy_res;
        logic [7:0] rx_byte;
        logic       rx_valid;
    } t_result;

endpackage

[hdl/sms_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shifter request channel
// Valid/ready channel that carries one action request to the shifter.
// ----------------------------------------------------------------------------
interface sms_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic       dc_bit;
    logic       miso_level;
    logic [1:0] mid_mode;
    logic       last_message;

    modport source (
        output valid, action, tx_byte, dc_bit, miso_level, mid_mode, last_message,
        input  ready
    );
    modport sink (
        input  valid, action, tx_byte, dc_bit, miso_level, mid_mode, last_message,
        output ready
    );
endinterface

[hdl/sms_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shifter response channel
// Valid/ready channel that carries the pin levels and receive status.
// ----------------------------------------------------------------------------
interface sms_rsp_if;
    logic       valid;
    logic       ready;
    logic       sck_level;
    logic       mosi_level;
    logic       cs_n;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       rx_valid;

    modport source (
        output valid, sck_level, mosi_level, cs_n, busy_res, rx_byte, rx_valid,
        input  ready
    );
    modport sink (
        input  valid, sck_level, mosi_level, cs_n, busy_res, rx_byte, rx_valid,
        output ready
    );
endinterface

[hdl/sms_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shifter step logic
// Next state and result for one request, from the current state and settings.
// ----------------------------------------------------------------------------
module sms_step
    import sms_pkg::*;
(
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    function automatic logic out_bit(input logic [7:0] v, input logic lsb);
        return lsb ? v[0] : v[7];
    endfunction

    function automatic logic [7:0] shift_in(input logic [7:0] v, input logic lsb,
                                            input logic miso);
        return lsb ? {miso, v[7:1]} : {v[6:0], miso};
    endfunction

    t_state n_st;
    logic   rx_valid;
    logic   dc_slot;

    always_comb begin
        n_st     = i_state;
        rx_valid = 1'b0;
        dc_slot  = (i_state.bits_left == BITS_NINE);
        case (i_item.action)
            ACT_TICK: begin
                if (i_state.bits_left != 4'd0) begin
                    if (!i_state.half_phase) begin
                        // Leading edge.
                        n_st.sck = ~i_cfg.clock_idle_high;
                        if (i_cfg.sample_second_edge) begin
                            n_st.mosi = dc_slot ? i_state.dc_pending
                                                : out_bit(i_state.shift_reg, i_cfg.lsb_first);
                        end else if (!dc_slot) begin
                            n_st.shift_reg = shift_in(i_state.shift_reg, i_cfg.lsb_first,
                                                      i_item.miso_level);
                        end
                        n_st.half_phase = 1'b1;
                    end else begin
                        // Trailing edge: clock back to idle, one bit done.
                        n_st.sck = i_cfg.clock_idle_high;
                        if (i_cfg.sample_second_edge && !dc_slot) begin
                            n_st.shift_reg = shift_in(i_state.shift_reg, i_cfg.lsb_first,
                                                      i_item.miso_level);
                        end
                        n_st.bits_left  = i_state.bits_left - 4'd1;
                        n_st.half_phase = 1'b0;
                        if (n_st.bits_left == 4'd0) begin
                            rx_valid = 1'b1;
                        end else if (!i_cfg.sample_second_edge) begin
                            n_st.mosi = out_bit(n_st.shift_reg, i_cfg.lsb_first);
                        end
                    end
                end
            end
            ACT_LOAD: begin
                if (i_state.bits_left == 4'd0) begin
                    n_st.shift_reg  = i_item.tx_byte;
                    n_st.half_phase = 1'b0;
                    n_st.bits_left  = i_cfg.nine_bit_frame ? BITS_NINE : BITS_BYTE;
                    n_st.dc_pending = i_cfg.nine_bit_frame & i_item.dc_bit;
                    if (!i_cfg.sample_second_edge) begin
                        n_st.mosi = i_cfg.nine_bit_frame ? i_item.dc_bit
                                  : out_bit(i_item.tx_byte, i_cfg.lsb_first);
                    end
                end
            end
            ACT_SELECT: begin
                n_st.cs = 1'b0;
            end
            default: begin
                case (i_item.mid_mode)
                    MID_STOP:      n_st.cs           = 1'b1;
                    MID_CONTINUE:  n_st.tail_release = 1'b1;
                    MID_EXIT_CONT: n_st.tail_release = 1'b0;
                    default:       ;
                endcase
                if (i_item.last_message) begin
                    if (n_st.tail_release) begin
                        n_st.cs = 1'b1;
                    end
                    n_st.tail_release = 1'b0;
                end
            end
        endcase
    end

    assign o_state = n_st;

    always_comb begin
        o_result.sck_level  = n_st.sck;
        o_result.mosi_level = n_st.mosi;
        o_result.cs_n       = n_st.cs;
        o_result.busy_res   = (n_st.bits_left != 4'd0);
        o_result.rx_byte    = rx_valid ? n_st.shift_reg : 8'd0;
        o_result.rx_valid   = rx_valid;
    end

endmodule

[hdl/spi_master_shifter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master shifter
// SPI master for clock modes 0 to 3 with MSB- or LSB-first order and an
// optional leading data/command bit, driven one half clock period per request.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Carries
//   i_req    in         valid/ready    action, tx_byte, dc_bit, miso_level,
//                                      mid_mode, last_message
//   o_rsp    out        valid/ready    sck_level, mosi_level, cs_n, busy_res,
//                                      rx_byte, rx_valid
//   i_cfg_*  in         write enable   index and one data bit per register
//
// Every accepted request has its response in the output register on the
// next cycle, so one request per clock is sustained while o_rsp keeps ready.
// This rate is set by the single pass through the step logic between the
// state registers and the response register.
// The request side stays ready while the response register is empty or is
// being drained in the same cycle; a stalled response holds the input off.
// Reset (synchronous, active low) deselects the device, parks the clock low,
// empties the response register and restores the register defaults.
// ----------------------------------------------------------------------------
module spi_master_shifter
    import sms_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sms_req_if.sink       i_req,
    sms_rsp_if.source     o_rsp,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic          i_cfg_data
);

    // Configuration registers.
    t_cfg    r_cfg;
    // Shifter state: shift register, bit counter, pin levels and tail flag.
    t_state  r_state;
    t_state  n_state;
    // Response register and its valid flag.
    t_result r_rsp;
    t_result n_rsp;
    logic    r_rsp_valid;

    t_item   w_item;
    logic    w_accept;

    // A request may enter whenever the response register will be free.
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        w_item.action       = t_action'(i_req.action);
        w_item.tx_byte      = i_req.tx_byte;
        w_item.dc_bit       = i_req.dc_bit;
        w_item.miso_level   = i_req.miso_level;
        w_item.mid_mode     = t_mid_mode'(i_req.mid_mode);
        w_item.last_message = i_req.last_message;
    end

    sms_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (w_item),
        .o_state  (n_state),
        .o_result (n_rsp)
    );

    // Configuration writes must come only while idle; this is not enforced.
    // Idle, with no request taken, a polarity write moves the idle clock at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_idle_high    <= 1'b0;
            r_cfg.sample_second_edge <= 1'b1;
            r_cfg.lsb_first          <= 1'b0;
            r_cfg.nine_bit_frame     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CLOCK_IDLE_HIGH:    r_cfg.clock_idle_high    <= i_cfg_data;
                REG_SAMPLE_SECOND_EDGE: r_cfg.sample_second_edge <= i_cfg_data;
                REG_LSB_FIRST:          r_cfg.lsb_first          <= i_cfg_data;
                REG_NINE_BIT_FRAME:     r_cfg.nine_bit_frame     <= i_cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{shift_reg: 8'd0, bits_left: 4'd0, half_phase: 1'b0,
                         dc_pending: 1'b0, sck: 1'b0, mosi: 1'b0, cs: 1'b1,
                         tail_release: 1'b0};
        end else if (w_accept) begin
            r_state <= n_state;
        end else if (i_cfg_we && (t_reg_idx'(i_cfg_idx) == REG_CLOCK_IDLE_HIGH)
                     && (r_state.bits_left == 4'd0)) begin
            r_state.sck <= i_cfg_data;
        end
    end

    // Response register: loaded on every accepted request, drained by o_rsp.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.sck_level  = r_rsp.sck_level;
    assign o_rsp.mosi_level = r_rsp.mosi_level;
    assign o_rsp.cs_n       = r_rsp.cs_n;
    assign o_rsp.busy_res   = r_rsp.busy_res;
    assign o_rsp.rx_byte    = r_rsp.rx_byte;
    assign o_rsp.rx_valid   = r_rsp.rx_valid;

`ifndef SYNTHESIS
    // The bit counter never leaves the range of a nine-bit frame.
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bits_left <= BITS_NINE)
        else $error("bit counter out of range");

    // Between frames the clock sits at its idle level.
    a_idle_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bits_left == 4'd0) |-> (r_state.sck == r_cfg.clock_idle_high))
        else $error("clock not at idle level between frames");

    // Between frames the next edge is always a leading edge.
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bits_left == 4'd0) |-> !r_state.half_phase)
        else $error("half phase set while idle");

    // A completed frame is reported with the shifter idle.
    a_rx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.rx_valid) |-> !o_rsp.busy_res)
        else $error("receive reported while busy");

    // Every accepted request leaves a response in the output register.
    a_accept_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_rsp_valid)
        else $error("accepted request without response");
`endif

endmodule
